// ===== rtl/core/hhd_pkg.sv =====
// Package: types, result kinds and the fixed code book of the header string decoder.
`default_nettype none
package hhd_pkg;

  localparam int unsigned StoreW = 37;
  localparam int unsigned HeldW = 6;
  localparam int unsigned MaxLen = 30;
  localparam int unsigned MinLen = 5;
  localparam int unsigned MaxPad = 7;
  localparam int unsigned NumSym = 256;

  localparam logic [1:0] KIND_SYM = 2'd0;
  localparam logic [1:0] KIND_OK  = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;

  typedef struct packed {
    logic load;
    logic consume;
    logic nomatch;
    logic endst;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic pend_valid;
    logic out_free;
    logic eos;
  } stat_t;

  typedef struct packed {
    logic       hit;
    logic [7:0] sym;
    logic [4:0] len;
  } match_t;

  localparam logic [29:0] CodeTab [NumSym] = '{
    30'h1ff8, 30'h7fffd8, 30'hfffffe2, 30'hfffffe3,
    30'hfffffe4, 30'hfffffe5, 30'hfffffe6, 30'hfffffe7,
    30'hfffffe8, 30'hffffea, 30'h3ffffffc, 30'hfffffe9,
    30'hfffffea, 30'h3ffffffd, 30'hfffffeb, 30'hfffffec,
    30'hfffffed, 30'hfffffee, 30'hfffffef, 30'hffffff0,
    30'hffffff1, 30'hffffff2, 30'h3ffffffe, 30'hffffff3,
    30'hffffff4, 30'hffffff5, 30'hffffff6, 30'hffffff7,
    30'hffffff8, 30'hffffff9, 30'hffffffa, 30'hffffffb,
    30'h14, 30'h3f8, 30'h3f9, 30'hffa,
    30'h1ff9, 30'h15, 30'hf8, 30'h7fa,
    30'h3fa, 30'h3fb, 30'hf9, 30'h7fb,
    30'hfa, 30'h16, 30'h17, 30'h18,
    30'h0, 30'h1, 30'h2, 30'h19,
    30'h1a, 30'h1b, 30'h1c, 30'h1d,
    30'h1e, 30'h1f, 30'h5c, 30'hfb,
    30'h7ffc, 30'h20, 30'hffb, 30'h3fc,
    30'h1ffa, 30'h21, 30'h5d, 30'h5e,
    30'h5f, 30'h60, 30'h61, 30'h62,
    30'h63, 30'h64, 30'h65, 30'h66,
    30'h67, 30'h68, 30'h69, 30'h6a,
    30'h6b, 30'h6c, 30'h6d, 30'h6e,
    30'h6f, 30'h70, 30'h71, 30'h72,
    30'hfc, 30'h73, 30'hfd, 30'h1ffb,
    30'h7fff0, 30'h1ffc, 30'h3ffc, 30'h22,
    30'h7ffd, 30'h3, 30'h23, 30'h4,
    30'h24, 30'h5, 30'h25, 30'h26,
    30'h27, 30'h6, 30'h74, 30'h75,
    30'h28, 30'h29, 30'h2a, 30'h7,
    30'h2b, 30'h76, 30'h2c, 30'h8,
    30'h9, 30'h2d, 30'h77, 30'h78,
    30'h79, 30'h7a, 30'h7b, 30'h7ffe,
    30'h7fc, 30'h3ffd, 30'h1ffd, 30'hffffffc,
    30'hfffe6, 30'h3fffd2, 30'hfffe7, 30'hfffe8,
    30'h3fffd3, 30'h3fffd4, 30'h3fffd5, 30'h7fffd9,
    30'h3fffd6, 30'h7fffda, 30'h7fffdb, 30'h7fffdc,
    30'h7fffdd, 30'h7fffde, 30'hffffeb, 30'h7fffdf,
    30'hffffec, 30'hffffed, 30'h3fffd7, 30'h7fffe0,
    30'hffffee, 30'h7fffe1, 30'h7fffe2, 30'h7fffe3,
    30'h7fffe4, 30'h1fffdc, 30'h3fffd8, 30'h7fffe5,
    30'h3fffd9, 30'h7fffe6, 30'h7fffe7, 30'hffffef,
    30'h3fffda, 30'h1fffdd, 30'hfffe9, 30'h3fffdb,
    30'h3fffdc, 30'h7fffe8, 30'h7fffe9, 30'h1fffde,
    30'h7fffea, 30'h3fffdd, 30'h3fffde, 30'hfffff0,
    30'h1fffdf, 30'h3fffdf, 30'h7fffeb, 30'h7fffec,
    30'h1fffe0, 30'h1fffe1, 30'h3fffe0, 30'h1fffe2,
    30'h7fffed, 30'h3fffe1, 30'h7fffee, 30'h7fffef,
    30'hfffea, 30'h3fffe2, 30'h3fffe3, 30'h3fffe4,
    30'h7ffff0, 30'h3fffe5, 30'h3fffe6, 30'h7ffff1,
    30'h3ffffe0, 30'h3ffffe1, 30'hfffeb, 30'h7fff1,
    30'h3fffe7, 30'h7ffff2, 30'h3fffe8, 30'h1ffffec,
    30'h3ffffe2, 30'h3ffffe3, 30'h3ffffe4, 30'h7ffffde,
    30'h7ffffdf, 30'h3ffffe5, 30'hfffff1, 30'h1ffffed,
    30'h7fff2, 30'h1fffe3, 30'h3ffffe6, 30'h7ffffe0,
    30'h7ffffe1, 30'h3ffffe7, 30'h7ffffe2, 30'hfffff2,
    30'h1fffe4, 30'h1fffe5, 30'h3ffffe8, 30'h3ffffe9,
    30'hffffffd, 30'h7ffffe3, 30'h7ffffe4, 30'h7ffffe5,
    30'hfffec, 30'hfffff3, 30'hfffed, 30'h1fffe6,
    30'h3fffe9, 30'h1fffe7, 30'h1fffe8, 30'h7ffff3,
    30'h3fffea, 30'h3fffeb, 30'h1ffffee, 30'h1ffffef,
    30'hfffff4, 30'hfffff5, 30'h3ffffea, 30'h7ffff4,
    30'h3ffffeb, 30'h7ffffe6, 30'h3ffffec, 30'h3ffffed,
    30'h7ffffe7, 30'h7ffffe8, 30'h7ffffe9, 30'h7ffffea,
    30'h7ffffeb, 30'hffffffe, 30'h7ffffec, 30'h7ffffed,
    30'h7ffffee, 30'h7ffffef, 30'h7fffff0, 30'h3ffffee
  };

  localparam logic [4:0] LenTab [NumSym] = '{
    5'd13, 5'd23, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd28, 5'd24, 5'd30, 5'd28, 5'd28, 5'd30, 5'd28, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd30, 5'd28,
    5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28, 5'd28,
    5'd6, 5'd10, 5'd10, 5'd12, 5'd13, 5'd6, 5'd8, 5'd11,
    5'd10, 5'd10, 5'd8, 5'd11, 5'd8, 5'd6, 5'd6, 5'd6,
    5'd5, 5'd5, 5'd5, 5'd6, 5'd6, 5'd6, 5'd6, 5'd6,
    5'd6, 5'd6, 5'd7, 5'd8, 5'd15, 5'd6, 5'd12, 5'd10,
    5'd13, 5'd6, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7, 5'd7,
    5'd8, 5'd7, 5'd8, 5'd13, 5'd19, 5'd13, 5'd14, 5'd6,
    5'd15, 5'd5, 5'd6, 5'd5, 5'd6, 5'd5, 5'd6, 5'd6,
    5'd6, 5'd5, 5'd7, 5'd7, 5'd6, 5'd6, 5'd6, 5'd5,
    5'd6, 5'd7, 5'd6, 5'd5, 5'd5, 5'd6, 5'd7, 5'd7,
    5'd7, 5'd7, 5'd7, 5'd15, 5'd11, 5'd14, 5'd13, 5'd28,
    5'd20, 5'd22, 5'd20, 5'd20, 5'd22, 5'd22, 5'd22, 5'd23,
    5'd22, 5'd23, 5'd23, 5'd23, 5'd23, 5'd23, 5'd24, 5'd23,
    5'd24, 5'd24, 5'd22, 5'd23, 5'd24, 5'd23, 5'd23, 5'd23,
    5'd23, 5'd21, 5'd22, 5'd23, 5'd22, 5'd23, 5'd23, 5'd24,
    5'd22, 5'd21, 5'd20, 5'd22, 5'd22, 5'd23, 5'd23, 5'd21,
    5'd23, 5'd22, 5'd22, 5'd24, 5'd21, 5'd22, 5'd23, 5'd23,
    5'd21, 5'd21, 5'd22, 5'd21, 5'd23, 5'd22, 5'd23, 5'd23,
    5'd20, 5'd22, 5'd22, 5'd22, 5'd23, 5'd22, 5'd22, 5'd23,
    5'd26, 5'd26, 5'd20, 5'd19, 5'd22, 5'd23, 5'd22, 5'd25,
    5'd26, 5'd26, 5'd26, 5'd27, 5'd27, 5'd26, 5'd24, 5'd25,
    5'd19, 5'd21, 5'd26, 5'd27, 5'd27, 5'd26, 5'd27, 5'd24,
    5'd21, 5'd21, 5'd26, 5'd26, 5'd28, 5'd27, 5'd27, 5'd27,
    5'd20, 5'd24, 5'd20, 5'd21, 5'd22, 5'd21, 5'd21, 5'd23,
    5'd22, 5'd22, 5'd25, 5'd25, 5'd24, 5'd24, 5'd26, 5'd23,
    5'd26, 5'd27, 5'd26, 5'd26, 5'd27, 5'd27, 5'd27, 5'd27,
    5'd27, 5'd28, 5'd27, 5'd27, 5'd27, 5'd27, 5'd27, 5'd26
  };

  function automatic match_t find_code(logic [29:0] lead, logic [HeldW-1:0] held);
    match_t m;
    m = '0;
    for (int s = 0; s < NumSym; s++) begin
      if ((HeldW'(LenTab[s]) <= held) && ((lead >> (5'd30 - LenTab[s])) == CodeTab[s])) begin
        m.hit = 1'b1;
        m.sym = m.sym | 8'(s);
        m.len = m.len | LenTab[s];
      end
    end
    return m;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/hhd_datapath.sv =====
// Datapath: bit store, prefix matcher, pending result and output register.
`default_nettype none
module hhd_datapath (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire hhd_pkg::cmd_t cmd_i,
  output hhd_pkg::stat_t    stat_o,
  input  wire logic [7:0]   coded_byte_i,
  input  wire logic         end_of_string_i,
  input  wire logic         out_stall_i,
  output logic              out_valid_o,
  output logic [1:0]        kind_o,
  output logic [7:0]        symbol_o,
  output logic              run_last_o
);
  import hhd_pkg::*;

  logic [StoreW-1:0] store_q, store_d;
  logic [HeldW-1:0]  held_q, held_d;
  logic              err_q, err_d;
  logic              eos_q, eos_d;
  logic              pend_v_q, pend_v_d;
  logic [1:0]        pend_kind_q, pend_kind_d;
  logic [7:0]        pend_sym_q, pend_sym_d;
  logic              out_v_q, out_v_d;
  logic [1:0]        out_kind_q, out_kind_d;
  logic [7:0]        out_sym_q, out_sym_d;
  logic              out_last_q, out_last_d;
  logic [StoreW-1:0] aligned;
  logic [HeldW-1:0]  rest;
  logic [7:0]        padmask;
  logic              bad;
  logic              out_free;
  match_t            m;

  always_comb begin
    aligned  = store_q << (HeldW'(StoreW) - held_q);
    m        = find_code(aligned[StoreW-1 -: MaxLen], held_q);
    rest     = held_q - HeldW'(m.len);
    out_free = !out_v_q || !out_stall_i;
    padmask  = 8'hff >> (4'd8 - {1'b0, held_q[2:0]});
    bad      = err_q || (held_q > HeldW'(MaxPad)) ||
               ((held_q != '0) && ((store_q[7:0] & padmask) != padmask));

    stat_o.match      = m.hit && (held_q >= HeldW'(MinLen));
    stat_o.pend_valid = pend_v_q;
    stat_o.out_free   = out_free;
    stat_o.eos        = eos_q;

    store_d     = store_q;
    held_d      = held_q;
    err_d       = err_q;
    eos_d       = eos_q;
    pend_v_d    = pend_v_q;
    pend_kind_d = pend_kind_q;
    pend_sym_d  = pend_sym_q;
    out_v_d     = out_v_q && out_stall_i;
    out_kind_d  = out_kind_q;
    out_sym_d   = out_sym_q;
    out_last_d  = out_last_q;

    if (cmd_i.load) begin
      eos_d = end_of_string_i;
      if (!err_q) begin
        store_d = {store_q[StoreW-9:0], coded_byte_i};
        held_d  = held_q + HeldW'(8);
      end
    end
    if ((cmd_i.consume || cmd_i.endst || cmd_i.flush) && pend_v_q) begin
      out_v_d    = 1'b1;
      out_kind_d = pend_kind_q;
      out_sym_d  = pend_sym_q;
      out_last_d = cmd_i.flush;
    end
    if (cmd_i.consume) begin
      pend_v_d    = 1'b1;
      pend_kind_d = KIND_SYM;
      pend_sym_d  = m.sym;
      held_d      = rest;
      store_d     = store_q & ~({StoreW{1'b1}} << rest);
    end
    if (cmd_i.nomatch && (held_q >= HeldW'(MaxLen))) begin
      err_d   = 1'b1;
      store_d = '0;
      held_d  = '0;
    end
    if (cmd_i.endst) begin
      pend_v_d    = 1'b1;
      pend_kind_d = bad ? KIND_ERR : KIND_OK;
      pend_sym_d  = '0;
      store_d     = '0;
      held_d      = '0;
      err_d       = 1'b0;
    end
    if (cmd_i.flush) begin
      pend_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      store_q  <= '0;
      held_q   <= '0;
      err_q    <= 1'b0;
      eos_q    <= 1'b0;
      pend_v_q <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      store_q  <= store_d;
      held_q   <= held_d;
      err_q    <= err_d;
      eos_q    <= eos_d;
      pend_v_q <= pend_v_d;
      out_v_q  <= out_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_kind_q <= pend_kind_d;
    pend_sym_q  <= pend_sym_d;
    out_kind_q  <= out_kind_d;
    out_sym_q   <= out_sym_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o = out_v_q;
  assign kind_o      = out_kind_q;
  assign symbol_o    = out_sym_q;
  assign run_last_o  = out_last_q;
endmodule
`default_nettype wire

// ===== rtl/core/hhd_ctrl.sv =====
// Controller: sequences load, symbol matching, end status and flush per beat.
`default_nettype none
module hhd_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire hhd_pkg::stat_t stat_i,
  output hhd_pkg::cmd_t      cmd_o
);
  import hhd_pkg::*;

  typedef enum logic [1:0] {IDLE, DECODE, FINISH, FLUSH} state_e;
  state_e state_q, state_d;
  logic   can_push;

  always_comb begin
    can_push = !stat_i.pend_valid || stat_i.out_free;
    state_d  = state_q;
    cmd_o    = '0;
    case (state_q)
      IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = DECODE;
        end
      end
      DECODE: begin
        if (can_push) begin
          if (stat_i.match) begin
            cmd_o.consume = 1'b1;
          end else begin
            cmd_o.nomatch = 1'b1;
            state_d       = FINISH;
          end
        end
      end
      FINISH: begin
        if (!stat_i.eos) begin
          state_d = FLUSH;
        end else if (can_push) begin
          cmd_o.endst = 1'b1;
          state_d     = FLUSH;
        end
      end
      FLUSH: begin
        if (!stat_i.pend_valid) begin
          state_d = IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.flush = 1'b1;
          state_d     = IDLE;
        end
      end
      default: state_d = IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != IDLE);
endmodule
`default_nettype wire

// ===== rtl/core/hpack_huffman_decoder_top.sv =====
// Each result of a beat passes through the pending register and then the output register.
// A new coded byte is taken only once the last beat is done; one symbol per cycle, while the
// output is not stalled, from the single prefix matcher over the stored bits.
// Reset: asynchronous, active low; clears bit store, count, error flag, end flag, pending and output valid.
// Top level of the header string decoder.
`default_nettype none
module hpack_huffman_decoder_top (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] coded_byte_i,
  input  wire logic       end_of_string_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [1:0]      kind_o,
  output logic [7:0]      symbol_o,
  output logic            run_last_o
);
  import hhd_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  hhd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  hhd_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .coded_byte_i    (coded_byte_i),
    .end_of_string_i (end_of_string_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .kind_o          (kind_o),
    .symbol_o        (symbol_o),
    .run_last_o      (run_last_o)
  );
endmodule
`default_nettype wire

// ===== tb/hpack_huffman_decoder_top_test.sv =====
// Testbench for the header string Huffman decoder: random coded strings checked by a scoreboard.
`timescale 1ns / 1ps
module hpack_huffman_decoder_top_test;
  import hhd_pkg::*;

  typedef struct {
    logic [1:0] kind;
    logic [7:0] symbol;
    logic       run_last;
  } result_t;

  class decode_scoreboard;
    logic [36:0] store;
    int unsigned held;
    bit          err;
    result_t     pending[$];
    int          fails;

    function void clear();
      store = '0;
      held = 0;
      err = 0;
    endfunction

    function int find_symbol();
      logic [36:0] lead;
      for (int s = 0; s < NumSym; s++) begin
        if (LenTab[s] <= held) begin
          lead = (store >> (held - LenTab[s])) & ((37'd1 << LenTab[s]) - 1);
          if (lead == 37'(CodeTab[s])) return s;
        end
      end
      return -1;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      int s;
      int n;
      bit bad;
      result_t r;
      n = 0;
      if (!err) begin
        store = {store[28:0], b};
        held += 8;
        while (held >= MinLen) begin
          s = find_symbol();
          if (s < 0) begin
            if (held >= MaxLen) begin
              err = 1;
              store = '0;
              held = 0;
            end
            break;
          end
          held -= LenTab[s];
          store &= (37'd1 << held) - 1;
          r.kind = KIND_SYM;
          r.symbol = 8'(s);
          r.run_last = 0;
          pending.push_back(r);
          n++;
        end
      end
      if (last) begin
        bad = err || held > MaxPad;
        if (!bad && held > 0 && (store & ((37'd1 << held) - 1)) != (37'd1 << held) - 1)
          bad = 1;
        r.kind = bad ? KIND_ERR : KIND_OK;
        r.symbol = 0;
        r.run_last = 0;
        pending.push_back(r);
        n++;
        clear();
      end
      if (n > 0) pending[pending.size() - 1].run_last = 1;
    endfunction

    function void check_result(logic [1:0] k, logic [7:0] sy, logic rl);
      result_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat kind=%0d symbol=%0d run_last=%0d", $time, k, sy, rl);
        fails++;
        return;
      end
      e = pending.pop_front();
      if (k !== e.kind) begin
        $display("%0t: kind expected %0d actual %0d", $time, e.kind, k);
        fails++;
      end
      if (sy !== e.symbol) begin
        $display("%0t: symbol expected %0d actual %0d", $time, e.symbol, sy);
        fails++;
      end
      if (rl !== e.run_last) begin
        $display("%0t: run_last expected %0d actual %0d", $time, e.run_last, rl);
        fails++;
      end
    endfunction
  endclass

  logic       clk_i;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] coded_byte_i;
  logic       end_of_string_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [1:0] kind_o;
  logic [7:0] symbol_o;
  logic       run_last_o;

  decode_scoreboard board;
  int          burst_left;
  int          sent;
  logic        bits_q[$];

  hpack_huffman_decoder_top dut (.*);

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_result(kind_o, symbol_o, run_last_o);
  end

  // receiver: stall in stretches, with quiet periods
  int stall_mode;
  always @(posedge clk_i) begin
    if ($urandom_range(0, 99) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 3) == 0);
      default: out_stall_i <= ($urandom_range(0, 3) != 0);
    endcase
  end

  task automatic send_byte(logic [7:0] b, bit last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    in_valid_i <= 1'b1;
    coded_byte_i <= b;
    end_of_string_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_byte(b, last);
    sent++;
  endtask

  task automatic put_code(int s);
    for (int i = LenTab[s] - 1; i >= 0; i--) bits_q.push_back(CodeTab[s][i]);
  endtask

  // pack coded symbols into bytes and pad, optionally with broken padding
  task automatic send_string(int nsym, int pad_mode);
    logic [7:0] b;
    bits_q.delete();
    for (int i = 0; i < nsym; i++) begin
      if ($urandom_range(0, 9) < 7) put_code($urandom_range(32, 126));
      else put_code($urandom_range(0, 255));
    end
    if (pad_mode == 1) put_code(0);
    if (pad_mode == 2) for (int i = 0; i < 30; i++) bits_q.push_back(1'b1);
    while (bits_q.size() % 8 != 0)
      bits_q.push_back(pad_mode == 3 ? 1'($urandom_range(0, 1)) : 1'b1);
    if (pad_mode == 4) for (int i = 0; i < 8; i++) bits_q.push_back(1'b1);
    while (bits_q.size() > 0) begin
      for (int i = 7; i >= 0; i--) b[i] = bits_q.pop_front();
      send_byte(b, bits_q.size() == 0);
    end
  endtask

  initial begin
    board = new();
    board.clear();
    board.fails = 0;
    burst_left = 0;
    sent = 0;
    stall_mode = 0;
    rst_ni = 0;
    in_valid_i = 0;
    coded_byte_i = '0;
    end_of_string_i = 0;
    out_stall_i = 0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00, 0);
    send_byte(8'hff, 1);
    send_byte(8'hff, 0);
    send_byte(8'hff, 0);
    send_byte(8'hff, 0);
    send_byte(8'hff, 0);
    send_byte(8'h00, 1);
    send_byte(8'h07, 1);
    send_byte(8'h00, 1);
    send_byte(8'h08, 1);
    send_string(1, 0);
    send_string(3, 1);
    send_string(2, 2);
    send_string(2, 3);
    send_string(0, 4);
    send_string(5, 0);

    while (sent < 265) begin
      if ($urandom_range(0, 9) < 7) send_string($urandom_range(0, 8), $urandom_range(0, 9) < 7 ? 0
                                                  : $urandom_range(1, 4));
      else send_byte($urandom_range(0, 255), $urandom_range(0, 3) == 0);
    end
    send_byte(8'hff, 1);
    in_valid_i <= 1'b0;

    while (board.pending.size() > 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (board.fails == 0 && board.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #20ms;
    $display("Verification failed");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/core/hhd_pkg.sv
rtl/core/hhd_datapath.sv
rtl/core/hhd_ctrl.sv
rtl/core/hpack_huffman_decoder_top.sv
tb/hpack_huffman_decoder_top_test.sv
